FILE: rtl/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg: shared definitions for the array tree delete block
// Widths, function and status codes, sequencer states and the structs that
// run between the sequencer and the child index unit.
// ----------------------------------------------------------------------------
package abd_pkg;

    // Tree storage geometry.
    localparam int MAX_NODES = 1024;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CAP_W     = IDX_W + 1;
    localparam int CHILD_W   = IDX_W + 2;
    localparam int KEY_W     = 32;

    // Reset value of the active node count register.
    localparam logic [CAP_W-1:0] ACTIVE_RESET = CAP_W'(1024);
    localparam logic [CAP_W-1:0] CAP_MAX      = CAP_W'(MAX_NODES);

    // Function codes on the input channel.
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_REFUSED = 2'd1;
    localparam logic [1:0] STAT_BAD     = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_READ_WAIT,
        ST_D_SELF,
        ST_D_LEFT,
        ST_D_RIGHT,
        ST_W_LEFT,
        ST_W_RIGHT,
        ST_K_WAIT,
        ST_FINISH
    } state_t;

    // Request to the child index unit.
    typedef struct packed {
        logic [IDX_W-1:0] base;
        logic             go_right;
        logic [CAP_W-1:0] cap;
    } step_req_t;

    // Answer of the child index unit.
    typedef struct packed {
        logic [CHILD_W-1:0] child;
        logic               in_range;
    } step_rsp_t;

endpackage

FILE: rtl/abd_ram.sv
// ----------------------------------------------------------------------------
// abd_ram: simple dual port RAM
// One write port and one read port, read data registered, no reset.
// ----------------------------------------------------------------------------
module abd_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/abd_step.sv
// ----------------------------------------------------------------------------
// abd_step: child index unit
// Forms the left or right child slot of a node and checks it against the
// usable slot count. Shared by every tree step of the sequencer.
// ----------------------------------------------------------------------------
module abd_step
    import abd_pkg::*;
(
    input  step_req_t req,
    output step_rsp_t rsp
);

    logic [CHILD_W-1:0] child;

    // Child slot is 2i+1 on the left and 2i+2 on the right.
    always_comb begin
        child = {1'b0, req.base, 1'b0}
              + (req.go_right ? CHILD_W'(2) : CHILD_W'(1));
        rsp.child    = child;
        rsp.in_range = child < {1'b0, req.cap};
    end

endmodule

FILE: rtl/abd_ctrl.sv
// ----------------------------------------------------------------------------
// abd_ctrl: sequencer of the array tree delete block
// Takes one beat at a time, walks the tree through the two stores with the
// shared child index unit, and holds the result in an output register.
// ----------------------------------------------------------------------------
module abd_ctrl
    import abd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration.
    input  logic               cfg_we,
    input  logic [CAP_W-1:0]   cfg_wdata,
    // Input beat fields.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         s_func,
    input  logic [IDX_W-1:0]   s_node_index,
    input  logic [KEY_W-1:0]   s_write_key,
    input  logic               s_write_occupied,
    // Result beat fields.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [1:0]         m_status,
    output logic [KEY_W-1:0]   m_read_key,
    output logic               m_read_occupied,
    // Child index unit.
    output step_req_t          step_req,
    input  step_rsp_t          step_rsp,
    // Key store.
    output logic               key_we,
    output logic [IDX_W-1:0]   key_waddr,
    output logic [KEY_W-1:0]   key_wdata,
    output logic [IDX_W-1:0]   key_raddr,
    input  logic [KEY_W-1:0]   key_rdata,
    // Occupied marks.
    output logic               occ_we,
    output logic [IDX_W-1:0]   occ_waddr,
    output logic               occ_wdata,
    output logic [IDX_W-1:0]   occ_raddr,
    input  logic               occ_rdata
);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [CAP_W-1:0]   active_reg;
    logic               m_tvalid_reg;

    logic [1:0]         func_reg, func_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [KEY_W-1:0]   wkey_reg, wkey_next;
    logic               wocc_reg, wocc_next;
    logic [IDX_W-1:0]   s_reg, s_next;
    logic [IDX_W-1:0]   probe_reg;
    logic               probe_ok_reg;
    logic               has_l_reg, has_l_next;
    logic [1:0]         status_reg, status_next;
    logic [KEY_W-1:0]   rkey_reg, rkey_next;
    logic               rocc_reg, rocc_next;
    logic [1:0]         m_status_reg;
    logic [KEY_W-1:0]   m_key_reg;
    logic               m_occ_reg;

    logic [CAP_W-1:0]   cap;
    logic               idx_ok;
    logic               probe_full;
    logic               out_free;
    logic               accept;

    // Usable slot count saturates at the store depth.
    assign cap        = (active_reg > CAP_MAX) ? CAP_MAX : active_reg;
    assign idx_ok     = {1'b0, idx_reg} < cap;
    assign probe_full = probe_ok_reg & occ_rdata;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;

    assign m_tvalid        = m_tvalid_reg;
    assign m_status        = m_status_reg;
    assign m_read_key      = m_key_reg;
    assign m_read_occupied = m_occ_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == {IDX_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (func_reg != FUNC_NONE && !idx_ok) begin
                    state_next = ST_FINISH;
                end else if (func_reg == FUNC_READ) begin
                    state_next = ST_READ_WAIT;
                end else if (func_reg == FUNC_DELETE) begin
                    state_next = ST_D_SELF;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ_WAIT: state_next = ST_FINISH;
            ST_D_SELF:    state_next = occ_rdata ? ST_D_LEFT : ST_FINISH;
            ST_D_LEFT:    state_next = ST_D_RIGHT;
            ST_D_RIGHT:   state_next = probe_full ? ST_W_LEFT : ST_FINISH;
            ST_W_LEFT:    state_next = probe_full ? ST_W_LEFT : ST_W_RIGHT;
            ST_W_RIGHT:   state_next = probe_full ? ST_FINISH : ST_K_WAIT;
            ST_K_WAIT:    state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Store accesses, child unit requests and datapath updates.
    always_comb begin
        func_next   = func_reg;
        idx_next    = idx_reg;
        wkey_next   = wkey_reg;
        wocc_next   = wocc_reg;
        s_next      = s_reg;
        has_l_next  = has_l_reg;
        status_next = status_reg;
        rkey_next   = rkey_reg;
        rocc_next   = rocc_reg;

        key_we    = 1'b0;
        key_waddr = idx_reg;
        key_wdata = wkey_reg;
        key_raddr = idx_reg;
        occ_we    = 1'b0;
        occ_waddr = idx_reg;
        occ_wdata = wocc_reg;
        occ_raddr = idx_reg;

        step_req.base     = idx_reg;
        step_req.go_right = 1'b0;
        step_req.cap      = cap;

        case (state_reg)
            ST_CLEAR: begin
                occ_we    = 1'b1;
                occ_waddr = clr_cnt_reg;
                occ_wdata = 1'b0;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next = s_func;
                    idx_next  = s_node_index;
                    wkey_next = s_write_key;
                    wocc_next = s_write_occupied;
                end
            end
            ST_DISPATCH: begin
                status_next = STAT_DONE;
                rkey_next   = '0;
                rocc_next   = 1'b0;
                if (func_reg != FUNC_NONE && !idx_ok) begin
                    status_next = STAT_BAD;
                end else if (func_reg == FUNC_WRITE) begin
                    key_we = 1'b1;
                    occ_we = 1'b1;
                end
            end
            ST_READ_WAIT: begin
                rkey_next = key_rdata;
                rocc_next = occ_rdata;
            end
            ST_D_SELF: begin
                // Probe the left child of the node.
                occ_raddr = step_rsp.child[IDX_W-1:0];
                if (!occ_rdata) begin
                    status_next = STAT_BAD;
                end
            end
            ST_D_LEFT: begin
                // Left child known; probe the right child.
                has_l_next        = probe_full;
                step_req.go_right = 1'b1;
                occ_raddr         = step_rsp.child[IDX_W-1:0];
            end
            ST_D_RIGHT: begin
                if (!has_l_reg && !probe_full) begin
                    occ_we    = 1'b1;
                    occ_wdata = 1'b0;
                end else if (!probe_full) begin
                    status_next = STAT_REFUSED;
                end
                // Start the successor walk at the right child.
                s_next        = probe_reg;
                step_req.base = probe_reg;
                occ_raddr     = step_rsp.child[IDX_W-1:0];
            end
            ST_W_LEFT: begin
                if (probe_full) begin
                    s_next        = probe_reg;
                    step_req.base = probe_reg;
                end else begin
                    step_req.base     = s_reg;
                    step_req.go_right = 1'b1;
                end
                occ_raddr = step_rsp.child[IDX_W-1:0];
            end
            ST_W_RIGHT: begin
                if (probe_full) begin
                    status_next = STAT_REFUSED;
                end
                key_raddr = s_reg;
            end
            ST_K_WAIT: begin
                // Copy the successor key up and drop the successor.
                key_we    = 1'b1;
                key_wdata = key_rdata;
                occ_we    = 1'b1;
                occ_waddr = s_reg;
                occ_wdata = 1'b0;
            end
            ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            active_reg   <= ACTIVE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cfg_we) begin
                active_reg <= cfg_wdata;
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        idx_reg      <= idx_next;
        wkey_reg     <= wkey_next;
        wocc_reg     <= wocc_next;
        s_reg        <= s_next;
        has_l_reg    <= has_l_next;
        status_reg   <= status_next;
        rkey_reg     <= rkey_next;
        rocc_reg     <= rocc_next;
        probe_reg    <= step_rsp.child[IDX_W-1:0];
        probe_ok_reg <= step_rsp.in_range;
        if (state_reg == ST_FINISH && out_free) begin
            m_status_reg <= status_reg;
            m_key_reg    <= rkey_reg;
            m_occ_reg    <= rocc_reg;
        end
    end

    // An accepted beat closes the input until its result is registered.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input accepted while a beat is in work");

    // The key store is written only by a write item or the successor copy.
    a_key_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        key_we |-> (state_reg == ST_DISPATCH && func_reg == FUNC_WRITE)
                   || state_reg == ST_K_WAIT)
        else $error("unexpected key store write");

    // The successor candidate always lies inside the usable slots.
    a_succ_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_W_LEFT || state_reg == ST_W_RIGHT || state_reg == ST_K_WAIT)
        |-> ({1'b0, s_reg} < cap))
        else $error("successor slot out of range");

    // A new result appears only out of the finish state.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

endmodule

FILE: rtl/array_bst_delete.sv
// ----------------------------------------------------------------------------
// array_bst_delete: implicit binary search tree with node delete
// Slot-indexed tree in a key store and an occupied mark store; each beat
// writes a slot, reads a slot, deletes a node or is unused.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one operation per beat: s_tuser holds the
// function code, s_tdata the slot index, write key and write mark. The
// result channel returns exactly one beat per input beat with the status,
// and for a read the stored key and mark. cfg_we with cfg_wdata sets the
// number of usable slots; write it only while no beat is in work.
// Timing: one beat is worked at a time. From the accept to the result in the
// output register, a write or a rejected or unused item passes the dispatch
// step and a read adds a read wait; a delete reads the node's mark, ends there
// for an empty slot, else probes the left and the right child, and for a node
// with a right child walks left from it to the successor, reads its key and
// copies it up, or is refused if the successor has a right child. The block
// returns to idle as the result is registered. The walk costs one registered
// read of the occupied store per tree level through the shared child index
// unit. After reset the occupied store is swept to zero, one slot per cycle,
// over all 1024 slots; s_tready stays low during the sweep, configuration
// writes are still taken. When m_tready is low, the result waits in the
// output register and the block takes the next beat; it then holds that
// beat's result in its finish step until the register is free.
// ----------------------------------------------------------------------------
module array_bst_delete
    import abd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CAP_W-1:0]   cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [9:0] node_index, [41:10] write_key, [42] write_occupied, rest zero
    input  logic [47:0]        s_tdata,
    // [1:0] func
    input  logic [1:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [1:0] status, [33:2] read_key, [34] read_occupied, rest zero
    output logic [39:0]        m_tdata
);

    step_req_t          step_req;
    step_rsp_t          step_rsp;
    logic               key_we;
    logic [IDX_W-1:0]   key_waddr;
    logic [KEY_W-1:0]   key_wdata;
    logic [IDX_W-1:0]   key_raddr;
    logic [KEY_W-1:0]   key_rdata;
    logic               occ_we;
    logic [IDX_W-1:0]   occ_waddr;
    logic               occ_wdata;
    logic [IDX_W-1:0]   occ_raddr;
    logic               occ_rdata;
    logic [1:0]         m_status;
    logic [KEY_W-1:0]   m_read_key;
    logic               m_read_occupied;

    // Result beat packing.
    assign m_tdata = {5'b0, m_read_occupied, m_read_key, m_status};

    abd_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_func           (s_tuser),
        .s_node_index     (s_tdata[9:0]),
        .s_write_key      (s_tdata[41:10]),
        .s_write_occupied (s_tdata[42]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_status         (m_status),
        .m_read_key       (m_read_key),
        .m_read_occupied  (m_read_occupied),
        .step_req         (step_req),
        .step_rsp         (step_rsp),
        .key_we           (key_we),
        .key_waddr        (key_waddr),
        .key_wdata        (key_wdata),
        .key_raddr        (key_raddr),
        .key_rdata        (key_rdata),
        .occ_we           (occ_we),
        .occ_waddr        (occ_waddr),
        .occ_wdata        (occ_wdata),
        .occ_raddr        (occ_raddr),
        .occ_rdata        (occ_rdata)
    );

    abd_step u_step (
        .req (step_req),
        .rsp (step_rsp)
    );

    abd_ram #(
        .DATA_W (KEY_W),
        .ADDR_W (IDX_W)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    abd_ram #(
        .DATA_W (1),
        .ADDR_W (IDX_W)
    ) u_occ_ram (
        .aclk  (aclk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .raddr (occ_raddr),
        .rdata (occ_rdata)
    );

endmodule
